@@ src/crcfc_pkg.sv @@
// Shared types, constants and the CRC-16/MODBUS byte update for the frame checker.
// No dependencies; used by crcfc_core and crc16_frame_checker_unit.
package crcfc_pkg;

   localparam int unsigned COUNT_W = 11;
   localparam logic [COUNT_W-1:0] MAX_FRAME_BYTES = 11'd1024;
   localparam logic [COUNT_W-1:0] MIN_FRAME_BYTES = 11'd8;

   localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;
   localparam logic [15:0] CRC_INIT           = 16'hFFFF;

   localparam logic [7:0] REBOOT_CMD_RESET = 8'h02;

   // byte positions inside the frame header
   localparam logic [COUNT_W-1:0] POS_HEAD_FIRST  = 11'd0;
   localparam logic [COUNT_W-1:0] POS_HEAD_SECOND = 11'd1;
   localparam logic [COUNT_W-1:0] POS_COMMAND     = 11'd2;
   localparam logic [COUNT_W-1:0] POS_ACK         = 11'd3;
   localparam logic [COUNT_W-1:0] POS_LEN_HIGH    = 11'd4;
   localparam logic [COUNT_W-1:0] POS_LEN_LOW     = 11'd5;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_FIRST     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_SECOND    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REBOOT_COMMAND = 2'd2;

   typedef enum logic [1:0] {
      VERDICT_OK     = 2'd0,
      VERDICT_HEADER = 2'd1,
      VERDICT_CRC    = 2'd2,
      VERDICT_SHORT  = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [7:0] head_first;
      logic [7:0] head_second;
      logic [7:0] reboot_command;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] frame_bytes;
      logic               reboot_request;
      logic [15:0]        block_length;
      logic [7:0]         ack_wanted;
      logic [7:0]         command_code;
      verdict_type        verdict;
   } result_type;

   localparam int unsigned RSP_DATA_W = 48;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ src/crcfc_core.sv @@
// Frame state of the checker: header check, field capture, delayed CRC and verdict.
// Depends on crcfc_pkg. Advances one word per cycle when step is high.
module crcfc_core
   import crcfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic       frame_end,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         held0_ff, held0_in;
   logic [7:0]         held1_ff, held1_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         command_ff, command_in;
   logic [7:0]         ack_ff, ack_in;
   logic [15:0]        length_ff, length_in;
   logic               header_bad_ff, header_bad_in;
   logic [15:0]        check;
   verdict_type        verdict;

   always_comb begin
      header_bad_in = header_bad_ff;
      command_in    = command_ff;
      ack_in        = ack_ff;
      length_in     = length_ff;
      if ((count_ff == POS_HEAD_FIRST) && (rx_byte != cfg.head_first)) begin
         header_bad_in = 1'b1;
      end
      if ((count_ff == POS_HEAD_SECOND) && (rx_byte != cfg.head_second)) begin
         header_bad_in = 1'b1;
      end
      if (count_ff == POS_COMMAND) begin
         command_in = rx_byte;
      end
      if (count_ff == POS_ACK) begin
         ack_in = rx_byte;
      end
      if (count_ff == POS_LEN_HIGH) begin
         length_in = {rx_byte, 8'h00};
      end
      if (count_ff == POS_LEN_LOW) begin
         length_in = {length_ff[15:8], rx_byte};
      end

      // the CRC trails the input by two bytes: the last two are the check value
      crc_in   = (count_ff >= POS_COMMAND) ? crc16_byte(crc_ff, held0_ff) : crc_ff;
      held0_in = held1_ff;
      held1_in = rx_byte;
      count_in = (count_ff < MAX_FRAME_BYTES) ? count_ff + 1'b1 : count_ff;

      check = {held1_in, held0_in};
      priority if (count_in < MIN_FRAME_BYTES) begin
         verdict = VERDICT_SHORT;
      end else if (header_bad_in) begin
         verdict = VERDICT_HEADER;
      end else if (check != crc_in) begin
         verdict = VERDICT_CRC;
      end else begin
         verdict = VERDICT_OK;
      end

      res_valid          = step && frame_end;
      res.verdict        = verdict;
      res.command_code   = command_in;
      res.ack_wanted     = ack_in;
      res.block_length   = length_in;
      res.reboot_request = (verdict == VERDICT_OK) && (command_in == cfg.reboot_command);
      res.frame_bytes    = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && frame_end)) begin
         crc_ff        <= CRC_INIT;
         held0_ff      <= 8'h00;
         held1_ff      <= 8'h00;
         count_ff      <= '0;
         command_ff    <= 8'h00;
         ack_ff        <= 8'h00;
         length_ff     <= 16'h0000;
         header_bad_ff <= 1'b0;
      end else if (step) begin
         crc_ff        <= crc_in;
         held0_ff      <= held0_in;
         held1_ff      <= held1_in;
         count_ff      <= count_in;
         command_ff    <= command_in;
         ack_ff        <= ack_in;
         length_ff     <= length_in;
         header_bad_ff <= header_bad_in;
      end
   end

endmodule

@@ src/crc16_frame_checker_unit.sv @@
// CRC-16/MODBUS frame checker: input word register, frame core, result register.
// A tlast byte enters the input word register, and its verdict the result register.
// Throughput: one byte per cycle unless rsp_tready stalls; the path from the input
// register via the unrolled byte-wide CRC update and check compare sets the cycle.
// Reset (synchronous, active high) clears the frame state, empties both
// registers and returns the header and reboot command registers to 0, 0 and 2.
module crc16_frame_checker_unit
   import crcfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   input  logic                   req_tlast,   // frame_end
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] verdict, [9:2] command_code, [17:10] ack_wanted, [33:18] block_length,
   // [34] reboot_request, [45:35] frame_bytes, [47:46] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   cfg_type     cfg_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   logic        advance;
   logic        step;
   logic        res_valid;
   result_type  res;

   assign csr_ready  = 1'b1;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_first     <= 8'h00;
         cfg_ff.head_second    <= 8'h00;
         cfg_ff.reboot_command <= REBOOT_CMD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEAD_FIRST:     cfg_ff.head_first     <= csr_wdata;
            CSR_HEAD_SECOND:    cfg_ff.head_second    <= csr_wdata;
            CSR_REBOOT_COMMAND: cfg_ff.reboot_command <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   crcfc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .frame_end (in_last_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (in_valid_ff && in_last_ff && advance))
      else $error("result produced without a last word in the input register");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("input register changed while stalled");

   a_reboot_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.reboot_request) |-> (rsp_ff.verdict == VERDICT_OK))
      else $error("reboot request on a frame that is not ok");

   a_short_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.verdict == VERDICT_SHORT) == (rsp_ff.frame_bytes < MIN_FRAME_BYTES)))
      else $error("too-short verdict disagrees with frame byte count");

endmodule

@@ verif/crc16_frame_checker_unit_tb.sv @@
// Self-checking bench for crc16_frame_checker_unit: streams good, corrupted, short and
// noise frames under several header settings and checks every verdict word.
// Depends on crcfc_pkg and the unit RTL; needs no files or arguments.
module crc16_frame_checker_unit_tb;
   import crcfc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL_CYCLES = 4;     // idle margin after the last verdict word
   localparam int PHASE_BYTES = 175;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;   // unmapped, writes dropped

   // Tracks one frame at a time and queues the verdict word each frame end should give.
   class frame_verdict_tracker;
      logic [7:0]         head_first;
      logic [7:0]         head_second;
      logic [7:0]         reboot_command;
      logic [15:0]        crc_acc;
      logic [7:0]         held_old;
      logic [7:0]         held_new;
      logic [COUNT_W-1:0] byte_count;
      logic [7:0]         cmd_seen;
      logic [7:0]         ack_seen;
      logic [15:0]        length_seen;
      bit                 header_bad;
      result_type         pending_verdicts[$];
      int                 mismatches;

      function new();
         head_first     = 8'h00;
         head_second    = 8'h00;
         reboot_command = REBOOT_CMD_RESET;
         mismatches     = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         crc_acc     = CRC_INIT;
         held_old    = 8'h00;
         held_new    = 8'h00;
         byte_count  = '0;
         cmd_seen    = 8'h00;
         ack_seen    = 8'h00;
         length_seen = 16'h0000;
         header_bad  = 1'b0;
      endfunction

      // reflected MODBUS update, one data bit at a time
      function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] data);
         logic [15:0] r;
         r = acc;
         for (int k = 0; k < 8; k++) begin
            if (r[0] ^ data[k]) begin
               r = (r >> 1) ^ CRC_POLY_REFLECTED;
            end else begin
               r = r >> 1;
            end
         end
         return r;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
         case (idx)
            CSR_HEAD_FIRST: begin
               head_first = val;
            end
            CSR_HEAD_SECOND: begin
               head_second = val;
            end
            CSR_REBOOT_COMMAND: begin
               reboot_command = val;
            end
            default: begin
            end
         endcase
      endfunction

      function void take_byte(logic [7:0] b, bit last);
         logic [COUNT_W-1:0] pos;
         result_type         r;
         pos = byte_count;
         if (pos == POS_HEAD_FIRST && b != head_first) header_bad = 1'b1;
         if (pos == POS_HEAD_SECOND && b != head_second) header_bad = 1'b1;
         if (pos == POS_COMMAND) cmd_seen = b;
         if (pos == POS_ACK) ack_seen = b;
         if (pos == POS_LEN_HIGH) length_seen = {b, 8'h00};
         if (pos == POS_LEN_LOW) length_seen[7:0] = b;
         // the last two words of a frame stay in the delay line, out of the CRC
         if (pos >= POS_COMMAND) crc_acc = crc_step(crc_acc, held_old);
         held_old = held_new;
         held_new = b;
         if (byte_count < MAX_FRAME_BYTES) byte_count = byte_count + 1'b1;
         if (last) begin
            if (byte_count < MIN_FRAME_BYTES) begin
               r.verdict = VERDICT_SHORT;
            end else if (header_bad) begin
               r.verdict = VERDICT_HEADER;
            end else if ({held_new, held_old} != crc_acc) begin
               r.verdict = VERDICT_CRC;
            end else begin
               r.verdict = VERDICT_OK;
            end
            r.command_code   = cmd_seen;
            r.ack_wanted     = ack_seen;
            r.block_length   = length_seen;
            r.reboot_request = (r.verdict == VERDICT_OK) && (cmd_seen == reboot_command);
            r.frame_bytes    = byte_count;
            pending_verdicts.push_back(r);
            clear_frame();
         end
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      task flag_mismatch(string what, longint unsigned got, longint unsigned want);
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
         mismatches++;
      endtask

      task match_result(result_type got);
         result_type want;
         if (pending_verdicts.size() == 0) begin
            flag_mismatch("verdict word with none pending", 64'(got), 0);
         end else begin
            want = pending_verdicts.pop_front();
            if (got.verdict != want.verdict)
               flag_mismatch("verdict", 64'(got.verdict), 64'(want.verdict));
            if (got.command_code != want.command_code)
               flag_mismatch("command_code", 64'(got.command_code), 64'(want.command_code));
            if (got.ack_wanted != want.ack_wanted)
               flag_mismatch("ack_wanted", 64'(got.ack_wanted), 64'(want.ack_wanted));
            if (got.block_length != want.block_length)
               flag_mismatch("block_length", 64'(got.block_length), 64'(want.block_length));
            if (got.reboot_request != want.reboot_request)
               flag_mismatch("reboot_request", 64'(got.reboot_request),
                             64'(want.reboot_request));
            if (got.frame_bytes != want.frame_bytes)
               flag_mismatch("frame_bytes", 64'(got.frame_bytes), 64'(want.frame_bytes));
         end
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'h00;   // [7:0] rx_byte
   logic                   req_tlast  = 1'b0;    // frame_end
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;            // result_type from bit 0, zero padded
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_HEAD_FIRST;
   logic [7:0]             csr_wdata  = 8'h00;

   frame_verdict_tracker tracker;
   logic [7:0]           frame_buf[$];
   int                   burst_left    = 0;
   logic [15:0]          ready_pattern = 16'hFFFF;
   int                   rx_cycle      = 0;

   crc16_frame_checker_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // now and then a long burst with no idle at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                                 : $urandom_range(1, 12);
   endtask

   task automatic send_word(logic [7:0] b, bit last);
      if (burst_left == 0) idle_gap();
      burst_left--;
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_byte(b, last);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++) begin
         send_word(frame_buf[i], i == frame_buf.size() - 1);
      end
   endtask

   // header, command, ack, length (high first), payload, then CRC low byte first
   function automatic void build_frame(input logic [7:0] h0, input logic [7:0] h1,
                                       input logic [7:0] cmd, input logic [7:0] ack,
                                       input logic [15:0] len, input int payload);
      logic [15:0] acc;
      frame_buf.delete();
      frame_buf.push_back(h0);
      frame_buf.push_back(h1);
      frame_buf.push_back(cmd);
      frame_buf.push_back(ack);
      frame_buf.push_back(len[15:8]);
      frame_buf.push_back(len[7:0]);
      for (int i = 0; i < payload; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
      acc = CRC_INIT;
      foreach (frame_buf[i]) acc = tracker.crc_step(acc, frame_buf[i]);
      frame_buf.push_back(acc[7:0]);
      frame_buf.push_back(acc[15:8]);
   endfunction

   task automatic send_random_frame();
      int          kind;
      int          n;
      int          spot;
      logic [7:0]  cmd;
      logic [7:0]  ack;
      logic [15:0] len;
      logic [7:0]  h0;
      logic [7:0]  h1;
      kind = $urandom_range(0, 99);
      cmd  = ($urandom_range(0, 3) == 0) ? tracker.reboot_command
                                          : 8'($urandom_range(0, 255));
      ack  = 8'($urandom_range(0, 255));
      len  = 16'($urandom_range(0, 65535));
      h0   = tracker.head_first;
      h1   = tracker.head_second;
      if (kind < 60) begin
         build_frame(h0, h1, cmd, ack, len, $urandom_range(0, 10));
      end else if (kind < 70) begin
         // one damaged word anywhere: header or CRC trouble
         build_frame(h0, h1, cmd, ack, len, $urandom_range(0, 10));
         spot = $urandom_range(0, frame_buf.size() - 1);
         frame_buf[spot] = frame_buf[spot] ^ 8'($urandom_range(1, 255));
      end else if (kind < 80) begin
         if ($urandom_range(0, 1) == 0) begin
            h0 = h0 ^ 8'($urandom_range(1, 255));
         end else begin
            h1 = h1 ^ 8'($urandom_range(1, 255));
         end
         build_frame(h0, h1, cmd, ack, len, $urandom_range(0, 10));
      end else if (kind < 90) begin
         n = $urandom_range(1, 7);
         if ($urandom_range(0, 1) == 0) begin
            build_frame(h0, h1, cmd, ack, len, 0);
            while (frame_buf.size() > n) void'(frame_buf.pop_back());
         end else begin
            frame_buf.delete();
            repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         frame_buf.delete();
         repeat ($urandom_range(1, 24)) frame_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_frame();
   endtask

   task automatic run_random(int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         send_random_frame();
         sent += frame_buf.size();
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_register(idx, val);
   endtask

   task automatic load_settings(logic [7:0] hf, logic [7:0] hs, logic [7:0] rc);
      write_csr(CSR_HEAD_FIRST, hf);
      write_csr(CSR_HEAD_SECOND, hs);
      write_csr(CSR_REBOOT_COMMAND, rc);
      csr_valid <= 1'b0;
   endtask

   // every frame ends with tlast, so an empty queue plus the latency means idle
   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.match_result(rsp_tdata[$bits(result_type)-1:0]);
      if (rx_cycle % 80 == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               ready_pattern = 16'hFFFF;
            end
            1: begin
               ready_pattern = 16'($urandom);
            end
            2: begin
               ready_pattern = 16'($urandom & $urandom & $urandom);
            end
            default: begin
               ready_pattern = 16'h0001;
            end
         endcase
         if (ready_pattern == 16'h0000) ready_pattern = 16'h8000;
      end
      rsp_tready <= ready_pattern[rx_cycle[3:0]];
      rx_cycle++;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("crc16_frame_checker_unit verification failed");
      $finish;
   end

   initial begin
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: clean reboot frame, one-word frame, seven-word frame, bad check
      build_frame(8'h00, 8'h00, REBOOT_CMD_RESET, 8'h00, 16'h0000, 0);
      send_frame();
      frame_buf.delete();
      frame_buf.push_back(8'hFF);
      send_frame();
      build_frame(8'h00, 8'h00, REBOOT_CMD_RESET, 8'hFF, 16'hFFFF, 0);
      void'(frame_buf.pop_back());
      send_frame();
      build_frame(8'h00, 8'h00, 8'hFF, 8'hFF, 16'hFFFF, 0);
      frame_buf[7] = frame_buf[7] ^ 8'h01;
      send_frame();
      drain();

      write_csr(CSR_SPARE, 8'h3C);
      load_settings(8'hFF, 8'hFF, 8'hFF);
      run_random(PHASE_BYTES);
      drain();

      load_settings(8'h00, 8'hFF, 8'h00);
      run_random(PHASE_BYTES);
      drain();

      load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      run_random(PHASE_BYTES);
      drain();

      load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      run_random(PHASE_BYTES);
      // one frame around the byte counter's saturation point
      build_frame(tracker.head_first, tracker.head_second, tracker.reboot_command,
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  $urandom_range(1014, 1026));
      send_frame();
      drain();

      if (tracker.pending() != 0)
         tracker.flag_mismatch("verdict words never delivered", 64'(tracker.pending()), 0);
      if (tracker.mismatches == 0) begin
         $display("crc16_frame_checker_unit verification clean");
      end else begin
         $display("crc16_frame_checker_unit verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/crcfc_pkg.sv
src/crcfc_core.sv
src/crc16_frame_checker_unit.sv
verif/crc16_frame_checker_unit_tb.sv
